@@ sv/ldpm_pkg.sv @@
// ----------------------------------------------------------------------------
// ldpm_pkg
// Shared types, constants and fixed point helpers for the lens distortion
// point map.
// ----------------------------------------------------------------------------
package ldpm_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int SUM_W  = 48;
  localparam int M28_W  = 36;
  localparam int M27_W  = 37;
  localparam int TS_W   = 39;

  localparam logic [2:0] REG_PP    = 3'd0;
  localparam logic [2:0] REG_INV_X = 3'd1;
  localparam logic [2:0] REG_INV_Y = 3'd2;
  localparam logic [2:0] REG_K1    = 3'd3;
  localparam logic [2:0] REG_K2    = 3'd4;
  localparam logic [2:0] REG_K3    = 3'd5;
  localparam logic [2:0] REG_P1    = 3'd6;
  localparam logic [2:0] REG_P2    = 3'd7;

  localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] S32_MIN = SUM_W'(-64'sd2147483648);
  localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(64'sd268435456);

  typedef struct packed {
    logic [23:0]        ppx;
    logic [23:0]        ppy;
    logic [31:0]        inv_fx;
    logic [31:0]        inv_fy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cfg_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
    logic               last;
  } norm_t;

  typedef struct packed {
    logic signed [31:0]     x;
    logic signed [31:0]     y;
    logic signed [31:0]     f;
    logic signed [TS_W-1:0] tx;
    logic signed [TS_W-1:0] ty;
    logic                   sat;
    logic                   last;
  } dist_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic               sat;
    logic               last;
  } res_t;

  function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
    sat_t s;
    s.clip = 1'b0;
    s.val  = v[31:0];
    if (v > S32_MAX) begin
      s.clip = 1'b1;
      s.val  = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      s.clip = 1'b1;
      s.val  = 32'sh80000000;
    end
    return s;
  endfunction

  function automatic logic signed [M28_W-1:0] mulsh28(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:28];
  endfunction

  function automatic logic signed [M27_W-1:0] mulsh27(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:27];
  endfunction

endpackage

@@ sv/ldpm_cfg.sv @@
// ----------------------------------------------------------------------------
// ldpm_cfg
// Register file behind the APB-style port: principal point, inverse focal
// lengths and distortion coefficients.
// ----------------------------------------------------------------------------
module ldpm_cfg import ldpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_PP: begin
          cfg_r.ppx <= pwdata[47:24];
          cfg_r.ppy <= pwdata[23:0];
        end
        REG_INV_X: cfg_r.inv_fx <= pwdata[31:0];
        REG_INV_Y: cfg_r.inv_fy <= pwdata[31:0];
        REG_K1:    cfg_r.k1 <= pwdata[31:0];
        REG_K2:    cfg_r.k2 <= pwdata[31:0];
        REG_K3:    cfg_r.k3 <= pwdata[31:0];
        REG_P1:    cfg_r.p1 <= pwdata[31:0];
        REG_P2:    cfg_r.p2 <= pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PP:    prdata = {16'd0, cfg_r.ppx, cfg_r.ppy};
      REG_INV_X: prdata = {32'd0, cfg_r.inv_fx};
      REG_INV_Y: prdata = {32'd0, cfg_r.inv_fy};
      REG_K1:    prdata = {32'd0, cfg_r.k1};
      REG_K2:    prdata = {32'd0, cfg_r.k2};
      REG_K3:    prdata = {32'd0, cfg_r.k3};
      REG_P1:    prdata = {32'd0, cfg_r.p1};
      REG_P2:    prdata = {32'd0, cfg_r.p2};
      default:   prdata = '0;
    endcase
  end

endmodule

@@ sv/ldpm_norm.sv @@
// ----------------------------------------------------------------------------
// ldpm_norm
// Three stage front end: principal point offset, scaling by the inverse
// focal length, and clipping to signed Q4.28.
// ----------------------------------------------------------------------------
module ldpm_norm import ldpm_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] pixel_x,
  input  logic [PIXEL_BITS-1:0] pixel_y,
  input  logic                  last_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output norm_t                 out_word
);

  localparam int N  = 3;
  localparam int DW = ((PIXEL_BITS + 12 > 24) ? PIXEL_BITS + 12 : 24) + 1;
  localparam int PW = DW + 33;

  logic [N-1:0] v_r;
  logic [N-1:0] en;

  logic signed [DW-1:0] dx_r, dy_r;
  logic                 last0_r;
  logic signed [PW-1:0] px_r, py_r;
  logic                 last1_r;
  norm_t                out_r;

  logic signed [DW-1:0] dx_nxt, dy_nxt;
  logic signed [PW-1:0] px_nxt, py_nxt;
  sat_t                 sx, sy;

  always_comb begin
    en[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    dx_nxt = DW'({pixel_x, 12'd0}) - DW'(cfg.ppx);
    dy_nxt = DW'({pixel_y, 12'd0}) - DW'(cfg.ppy);
    px_nxt = dx_r * $signed({1'b0, cfg.inv_fx});
    py_nxt = dy_r * $signed({1'b0, cfg.inv_fy});
    sx     = sat32(SUM_W'($signed(px_r[PW-1:16])));
    sy     = sat32(SUM_W'($signed(py_r[PW-1:16])));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      last0_r <= last_in;
    end
    if (en[1]) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      last1_r <= last0_r;
    end
    if (en[2]) begin
      out_r.x    <= sx.val;
      out_r.y    <= sy.val;
      out_r.sat  <= sx.clip || sy.clip;
      out_r.last <= last1_r;
    end
  end

endmodule

@@ sv/ldpm_radial.sv @@
// ----------------------------------------------------------------------------
// ldpm_radial
// Six stage middle section: squares, radius powers, radial factor and the
// tangential sums for both axes.
// ----------------------------------------------------------------------------
module ldpm_radial import ldpm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  norm_t in_word,
  output logic  out_valid,
  input  logic  out_ready,
  output dist_t out_word
);

  localparam int N = 6;

  logic [N-1:0] v_r;
  logic [N-1:0] en;

  // stage 0
  logic signed [31:0] s0_x_r, s0_y_r, s0_x2_r, s0_y2_r, s0_xy_r;
  logic               s0_sat_r, s0_last_r;
  // stage 1
  logic signed [31:0] s1_x_r, s1_y_r, s1_x2_r, s1_y2_r, s1_xy_r, s1_r2_r;
  logic               s1_sat_r, s1_last_r;
  // stage 2
  logic signed [31:0]      s2_x_r, s2_y_r, s2_r2_r, s2_r4_r;
  logic signed [M28_W-1:0] s2_t1_r, s2_txb_r, s2_tya_r;
  logic signed [M27_W-1:0] s2_txa_r, s2_txc_r, s2_tyb_r, s2_tyc_r;
  logic                    s2_sat_r, s2_last_r;
  // stage 3
  logic signed [31:0]      s3_x_r, s3_y_r, s3_r6_r;
  logic signed [M28_W-1:0] s3_t1_r, s3_t2_r;
  logic signed [TS_W-1:0]  s3_tx_r, s3_ty_r;
  logic                    s3_sat_r, s3_last_r;
  // stage 4
  logic signed [31:0]      s4_x_r, s4_y_r;
  logic signed [M28_W-1:0] s4_t1_r, s4_t2_r, s4_t3_r;
  logic signed [TS_W-1:0]  s4_tx_r, s4_ty_r;
  logic                    s4_sat_r, s4_last_r;
  // stage 5
  dist_t out_r;

  sat_t sx2, sy2, sxy, sr2, sr4, sr6, sf;

  always_comb begin
    en[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    sx2 = sat32(SUM_W'(mulsh28(in_word.x, in_word.x)));
    sy2 = sat32(SUM_W'(mulsh28(in_word.y, in_word.y)));
    sxy = sat32(SUM_W'(mulsh28(in_word.x, in_word.y)));
    sr2 = sat32(SUM_W'(s0_x2_r) + SUM_W'(s0_y2_r));
    sr4 = sat32(SUM_W'(mulsh28(s1_r2_r, s1_r2_r)));
    sr6 = sat32(SUM_W'(mulsh28(s2_r4_r, s2_r2_r)));
    sf  = sat32(ONE_Q28 + SUM_W'(s4_t1_r) + SUM_W'(s4_t2_r) + SUM_W'(s4_t3_r));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_x_r    <= in_word.x;
      s0_y_r    <= in_word.y;
      s0_x2_r   <= sx2.val;
      s0_y2_r   <= sy2.val;
      s0_xy_r   <= sxy.val;
      s0_sat_r  <= in_word.sat || sx2.clip || sy2.clip || sxy.clip;
      s0_last_r <= in_word.last;
    end
    if (en[1]) begin
      s1_x_r    <= s0_x_r;
      s1_y_r    <= s0_y_r;
      s1_x2_r   <= s0_x2_r;
      s1_y2_r   <= s0_y2_r;
      s1_xy_r   <= s0_xy_r;
      s1_r2_r   <= sr2.val;
      s1_sat_r  <= s0_sat_r || sr2.clip;
      s1_last_r <= s0_last_r;
    end
    if (en[2]) begin
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_r2_r   <= s1_r2_r;
      s2_r4_r   <= sr4.val;
      s2_t1_r   <= mulsh28(cfg.k1, s1_r2_r);
      s2_txa_r  <= mulsh27(cfg.p1, s1_xy_r);
      s2_txb_r  <= mulsh28(cfg.p2, s1_r2_r);
      s2_txc_r  <= mulsh27(cfg.p2, s1_x2_r);
      s2_tya_r  <= mulsh28(cfg.p1, s1_r2_r);
      s2_tyb_r  <= mulsh27(cfg.p1, s1_y2_r);
      s2_tyc_r  <= mulsh27(cfg.p2, s1_xy_r);
      s2_sat_r  <= s1_sat_r || sr4.clip;
      s2_last_r <= s1_last_r;
    end
    if (en[3]) begin
      s3_x_r    <= s2_x_r;
      s3_y_r    <= s2_y_r;
      s3_r6_r   <= sr6.val;
      s3_t1_r   <= s2_t1_r;
      s3_t2_r   <= mulsh28(cfg.k2, s2_r4_r);
      s3_tx_r   <= TS_W'(s2_txa_r) + TS_W'(s2_txb_r) + TS_W'(s2_txc_r);
      s3_ty_r   <= TS_W'(s2_tya_r) + TS_W'(s2_tyb_r) + TS_W'(s2_tyc_r);
      s3_sat_r  <= s2_sat_r || sr6.clip;
      s3_last_r <= s2_last_r;
    end
    if (en[4]) begin
      s4_x_r    <= s3_x_r;
      s4_y_r    <= s3_y_r;
      s4_t1_r   <= s3_t1_r;
      s4_t2_r   <= s3_t2_r;
      s4_t3_r   <= mulsh28(cfg.k3, s3_r6_r);
      s4_tx_r   <= s3_tx_r;
      s4_ty_r   <= s3_ty_r;
      s4_sat_r  <= s3_sat_r;
      s4_last_r <= s3_last_r;
    end
    if (en[5]) begin
      out_r.x    <= s4_x_r;
      out_r.y    <= s4_y_r;
      out_r.f    <= sf.val;
      out_r.tx   <= s4_tx_r;
      out_r.ty   <= s4_ty_r;
      out_r.sat  <= s4_sat_r || sf.clip;
      out_r.last <= s4_last_r;
    end
  end

endmodule

@@ sv/ldpm_out.sv @@
// ----------------------------------------------------------------------------
// ldpm_out
// Two stage back end: radial factor times the point, tangential sum added,
// clipped result held in the output register.
// ----------------------------------------------------------------------------
module ldpm_out import ldpm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  dist_t in_word,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_word
);

  localparam int N = 2;

  logic [N-1:0] v_r;
  logic [N-1:0] en;

  logic signed [M28_W-1:0] fx_r, fy_r;
  logic signed [TS_W-1:0]  tx_r, ty_r;
  logic                    sat_r, last_r;
  res_t                    out_r;

  sat_t sox, soy;

  always_comb begin
    en[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    sox = sat32(SUM_W'(fx_r) + SUM_W'(tx_r));
    soy = sat32(SUM_W'(fy_r) + SUM_W'(ty_r));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fx_r   <= mulsh28(in_word.f, in_word.x);
      fy_r   <= mulsh28(in_word.f, in_word.y);
      tx_r   <= in_word.tx;
      ty_r   <= in_word.ty;
      sat_r  <= in_word.sat;
      last_r <= in_word.last;
    end
    if (en[1]) begin
      out_r.cam_x <= sox.val;
      out_r.cam_y <= soy.val;
      out_r.sat   <= sat_r || sox.clip || soy.clip;
      out_r.last  <= last_r;
    end
  end

endmodule

@@ sv/lens_distortion_point_map.sv @@
// ----------------------------------------------------------------------------
// lens_distortion_point_map
// Maps pixel coordinates to distorted normalized camera coordinates with the
// Brown-Conrady radial and tangential model, signed Q4.28 out.
// ----------------------------------------------------------------------------
// One word is accepted per clock and one result leaves per clock while out_ready
// is high; a word passes eleven register stages (three normalize stages, six
// radial stages, two output stages, each at most one multiply deep). Every
// stage carries its own valid bit and advances when it is empty or the stage
// after it moves, so bubbles close up during an output stall and in_ready only
// drops once all eleven stages hold words. in_ready depends combinationally
// on out_ready. Registers are to be written only while the pipeline is empty;
// the block itself does not enforce this.
module lens_distortion_point_map import ldpm_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] in_pixel_x,
  input  logic [PIXEL_BITS-1:0] in_pixel_y,
  input  logic                  in_last_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_cam_x,
  output logic signed [31:0]    out_cam_y,
  output logic                  out_saturated,
  output logic                  out_last_out
);

  cfg_t  cfg;
  norm_t norm_word;
  dist_t dist_word;
  res_t  res_word;
  logic  norm_valid, norm_ready;
  logic  dist_valid, dist_ready;

  ldpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ldpm_norm #(.PIXEL_BITS(PIXEL_BITS)) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_x   (in_pixel_x),
    .pixel_y   (in_pixel_y),
    .last_in   (in_last_in),
    .out_valid (norm_valid),
    .out_ready (norm_ready),
    .out_word  (norm_word)
  );

  ldpm_radial u_radial (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (norm_valid),
    .in_ready  (norm_ready),
    .in_word   (norm_word),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .out_word  (dist_word)
  );

  ldpm_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dist_valid),
    .in_ready  (dist_ready),
    .in_word   (dist_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (res_word)
  );

  assign out_cam_x     = res_word.cam_x;
  assign out_cam_y     = res_word.cam_y;
  assign out_saturated = res_word.sat;
  assign out_last_out  = res_word.last;

`ifndef SYNTHESIS
  // input side only blocks when the whole chain is backed up
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && norm_valid && dist_valid))
    else $error("in_ready low while pipeline can still advance");

  // a write to any register but the principal point reads back on the following cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(psel && penable && pwrite) && paddr == $past(paddr)
     && paddr[ADDR_W-1:3] != REG_PP)
    |-> prdata[31:0] == $past(pwdata[31:0]))
    else $error("register readback mismatch");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_word)))
    else $error("output word changed under stall");
`endif

endmodule

@@ dv/ldpm_checker.sv @@
// ----------------------------------------------------------------------------
// ldpm_checker
// Watches the register port and both streams of the lens distortion point
// map, computes the distorted point for every accepted pixel word in fixed
// point and compares each result word against the oldest pending point.
// ----------------------------------------------------------------------------
module ldpm_checker import ldpm_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] in_pixel_x,
  input  logic [PIXEL_BITS-1:0] in_pixel_y,
  input  logic                  in_last_in,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [31:0]    out_cam_x,
  input  logic signed [31:0]    out_cam_y,
  input  logic                  out_saturated,
  input  logic                  out_last_out,
  output int                    mismatches,
  output int                    points_in_flight
);

  cfg_t lens;
  res_t mapped_q[$];
  res_t due;

  function automatic longint clip32(input longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint mul_floor(input longint a, input longint b, input int s);
    longint p;
    p = a * b;
    return p >>> s;
  endfunction

  function automatic longint to_norm(input logic [PIXEL_BITS-1:0] pix, input logic [23:0] pp,
                                     input logic [31:0] inv, inout bit hit);
    longint d;
    d = (longint'(pix) <<< 12) - longint'(pp);
    return clip32((d * longint'(inv)) >>> 16, hit);
  endfunction

  function automatic res_t distort_point(input cfg_t c, input logic [PIXEL_BITS-1:0] px,
                                         input logic [PIXEL_BITS-1:0] py, input logic last);
    res_t   r;
    bit     hit;
    longint x, y, x2, y2, xy, r2, r4, r6, f, ox, oy;
    hit = 1'b0;
    x  = to_norm(px, c.ppx, c.inv_fx, hit);
    y  = to_norm(py, c.ppy, c.inv_fy, hit);
    x2 = clip32(mul_floor(x, x, 28), hit);
    y2 = clip32(mul_floor(y, y, 28), hit);
    xy = clip32(mul_floor(x, y, 28), hit);
    r2 = clip32(x2 + y2, hit);
    r4 = clip32(mul_floor(r2, r2, 28), hit);
    r6 = clip32(mul_floor(r4, r2, 28), hit);
    f  = clip32((64'sd1 <<< 28) + mul_floor(c.k1, r2, 28) + mul_floor(c.k2, r4, 28)
                + mul_floor(c.k3, r6, 28), hit);
    ox = clip32(mul_floor(f, x, 28) + mul_floor(c.p1, xy, 27) + mul_floor(c.p2, r2, 28)
                + mul_floor(c.p2, x2, 27), hit);
    oy = clip32(mul_floor(f, y, 28) + mul_floor(c.p1, r2, 28) + mul_floor(c.p1, y2, 27)
                + mul_floor(c.p2, xy, 27), hit);
    r.cam_x = ox[31:0];
    r.cam_y = oy[31:0];
    r.sat   = hit;
    r.last  = last;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lens = '0;
      mapped_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_PP:    {lens.ppx, lens.ppy} = pwdata[47:0];
          REG_INV_X: lens.inv_fx = pwdata[31:0];
          REG_INV_Y: lens.inv_fy = pwdata[31:0];
          REG_K1:    lens.k1 = pwdata[31:0];
          REG_K2:    lens.k2 = pwdata[31:0];
          REG_K3:    lens.k3 = pwdata[31:0];
          REG_P1:    lens.p1 = pwdata[31:0];
          REG_P2:    lens.p2 = pwdata[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        mapped_q = {mapped_q, distort_point(lens, in_pixel_x, in_pixel_y, in_last_in)};
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected word expected none actual %h %h %b %b", $time,
                   out_cam_x, out_cam_y, out_saturated, out_last_out);
        end else begin
          due = mapped_q.pop_front();
          report("cam_x", due.cam_x, out_cam_x);
          report("cam_y", due.cam_y, out_cam_y);
          report("saturated", 32'(due.sat), 32'(out_saturated));
          report("last_out", 32'(due.last), 32'(out_last_out));
        end
      end
    end
    points_in_flight = mapped_q.size();
  end

endmodule

@@ dv/lens_distortion_point_map_tb.sv @@
// ----------------------------------------------------------------------------
// lens_distortion_point_map_tb
// Drives pixel words through the lens distortion point map under a series of
// lens settings, from reset values and extremes to random lenses, with random
// stalls on both streams; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module lens_distortion_point_map_tb;
  import ldpm_pkg::*;

  localparam int PIXEL_BITS = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIXEL_BITS-1:0] in_pixel_x;
  logic [PIXEL_BITS-1:0] in_pixel_y;
  logic                  in_last_in;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [31:0]    out_cam_x;
  logic signed [31:0]    out_cam_y;
  logic                  out_saturated;
  logic                  out_last_out;

  int mismatches;
  int points_in_flight;
  bit quiet;

  lens_distortion_point_map #(.PIXEL_BITS(PIXEL_BITS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_cam_x(out_cam_x),
    .out_cam_y(out_cam_y), .out_saturated(out_saturated), .out_last_out(out_last_out)
  );

  ldpm_checker #(.PIXEL_BITS(PIXEL_BITS)) u_chk (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_cam_x(out_cam_x),
    .out_cam_y(out_cam_y), .out_saturated(out_saturated), .out_last_out(out_last_out),
    .mismatches(mismatches), .points_in_flight(points_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side backpressure
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      n = $urandom_range(1, 40);
      out_ready = 1'b1;
      repeat (n) @(negedge clk);
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_lens(input logic [63:0] pp, input logic [63:0] ix, input logic [63:0] iy,
                          input logic [63:0] k1, input logic [63:0] k2, input logic [63:0] k3,
                          input logic [63:0] p1, input logic [63:0] p2);
    reg_write(REG_PP, pp);
    reg_write(REG_INV_X, ix);
    reg_write(REG_INV_Y, iy);
    reg_write(REG_K1, k1);
    reg_write(REG_K2, k2);
    reg_write(REG_K3, k3);
    reg_write(REG_P1, p1);
    reg_write(REG_P2, p2);
  endtask

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] small_coef(input int lo, input int hi);
    logic signed [31:0] v;
    v = $signed($urandom);
    return v >>> $urandom_range(lo, hi);
  endfunction

  task automatic random_lens(input int style);
    logic [23:0] ppx, ppy;
    case (style)
      0: begin
        ppx = 24'($urandom_range(0, 4095 * 4096));
        ppy = 24'($urandom_range(0, 4095 * 4096));
        set_lens({16'($urandom), ppx, ppy},
                 {$urandom, 32'($urandom_range(2147483, 8589934))},
                 {$urandom, 32'($urandom_range(2147483, 8589934))},
                 {$urandom, small_coef(2, 6)}, {$urandom, small_coef(3, 8)},
                 {$urandom, small_coef(4, 10)}, {$urandom, small_coef(6, 12)},
                 {$urandom, small_coef(6, 12)});
      end
      1: set_lens({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
      default: set_lens({corner_word(), corner_word()}, {32'h0, corner_word()},
                        {32'h0, corner_word()}, {32'h0, corner_word()},
                        {32'h0, corner_word()}, {32'h0, corner_word()},
                        {32'h0, corner_word()}, {32'h0, corner_word()});
    endcase
  endtask

  task automatic send_pixel(input int px, input int py, input bit last);
    int gap;
    @(negedge clk);
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_pixel_x = px[PIXEL_BITS-1:0];
    in_pixel_y = py[PIXEL_BITS-1:0];
    in_last_in = last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (points_in_flight != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    int styles[8];
    styles = '{0, 1, 0, 2, 0, 0, 1, 0};
    quiet      = 1'b0;
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_last_in = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset lens, zero inverse focal lengths
    send_pixel(0, 0, 1'b0);
    send_pixel(4095, 4095, 1'b1);
    send_pixel(4095, 0, 1'b0);
    send_pixel(0, 4095, 1'b1);
    settle();

    // typical lens around the image center
    set_lens(64'h7ff800_5ff400, 64'd3067834, 64'd3070000,
             64'(-32'sd80530637), 64'(32'sd32212255), 64'(-32'sd5368709),
             64'(32'sd268435), 64'(-32'sd134218));
    send_pixel(2047, 1535, 1'b0);
    send_pixel(2048, 1536, 1'b0);
    send_pixel(0, 0, 1'b0);
    send_pixel(4095, 4095, 1'b0);
    send_pixel(0, 4095, 1'b0);
    send_pixel(4095, 0, 1'b0);
    send_pixel(1000, 3000, 1'b0);
    send_pixel(3500, 200, 1'b0);
    send_pixel(2047, 0, 1'b0);
    send_pixel(0, 1535, 1'b1);
    settle();

    // extremes, heavy clipping
    set_lens(64'hffff_ffff_ffff, 64'hffff_ffff, 64'hffff_ffff,
             64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff, 64'h8000_0000, 64'h8000_0000);
    send_pixel(0, 0, 1'b0);
    send_pixel(4095, 4095, 1'b0);
    send_pixel(4095, 0, 1'b1);
    send_pixel(0, 4095, 1'b0);
    send_pixel(2048, 2048, 1'b1);
    settle();

    set_lens(64'h0, 64'hffff_ffff, 64'hffff_ffff,
             64'h8000_0000, 64'h8000_0000, 64'h8000_0000, 64'h7fff_ffff, 64'h7fff_ffff);
    send_pixel(1, 1, 1'b0);
    send_pixel(4095, 4095, 1'b0);
    send_pixel(0, 0, 1'b0);
    send_pixel(1, 0, 1'b0);
    send_pixel(0, 2, 1'b1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      random_lens(styles[ph]);
      if (ph == 7) quiet = 1'b1;
      for (int i = 0; i < 142; i++)
        send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 15) == 0);
      if (ph != 7) settle();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (points_in_flight != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatches == 0 && points_in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ldpm_pkg.sv
sv/ldpm_cfg.sv
sv/ldpm_norm.sv
sv/ldpm_radial.sv
sv/ldpm_out.sv
sv/lens_distortion_point_map.sv
dv/ldpm_checker.sv
dv/lens_distortion_point_map_tb.sv
